@@ src/tta_pkg.sv @@
// ----------------------------------------------------------------------------
// Tap tempo averager package
// Shared widths, constants, event codes, register indexes and the command
// record that travels from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package tta_pkg;

  // Field and state widths.
  localparam int INTERVAL_W = 13;
  localparam int PRESS_W    = 8;
  localparam int HIST_W     = 12;
  localparam int TEMPO_W    = 10;
  localparam int EV_W       = 2;

  localparam logic [INTERVAL_W-1:0] INTERVAL_MAX = '1;
  localparam logic [PRESS_W-1:0]    PRESS_MAX    = '1;
  localparam logic [TEMPO_W-1:0]    TEMPO_MAX    = '1;

  // Tap event codes.
  localparam logic [EV_W-1:0] EV_NONE    = 2'd0;
  localparam logic [EV_W-1:0] EV_SOON    = 2'd1;
  localparam logic [EV_W-1:0] EV_REC     = 2'd2;
  localparam logic [EV_W-1:0] EV_RESTART = 2'd3;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_INT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INT  = 2'd2;

  localparam logic [PRESS_W-1:0] DEBOUNCE_RST = 8'd100;
  localparam logic [HIST_W-1:0]  MIN_INT_RST  = 12'd200;
  localparam logic [HIST_W-1:0]  MAX_INT_RST  = 12'd4000;

  // Command queue between the two halves.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_LVL_W = $clog2(FIFO_DEPTH + 1);

  // One classified tick, as handed to the back end.
  typedef struct packed {
    logic              clear;
    logic [EV_W-1:0]   ev;
    logic [HIST_W-1:0] interval;
  } cmd_t;

endpackage

`default_nettype wire

@@ src/tap_tempo_interval_averager.sv @@
// ----------------------------------------------------------------------------
// Tap tempo interval averager
// Averages debounced tap intervals of a 0.25 ms tick stream into a tempo in
// milliseconds, with a front end that classifies ticks and a back end that
// keeps the interval ring and divides.
// ----------------------------------------------------------------------------
// Results: a plain tick's result is loaded straight into the output register,
// while a recorded interval's result waits for the serial divider, which
// gives one quotient bit per cycle.
// Throughput: up to one tick per cycle into a two-entry queue while it has
// room; the back end takes no new command while a division runs.
// Reset: synchronous; the configuration returns to its defaults, the interval
// counter saturates and ring, fill count and tempo clear in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tap_tempo_interval_averager #(
  parameter int HISTORY_DEPTH = 4,
  parameter int TICKS_PER_MS  = 4
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [tta_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tta_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           switch_pressed,
  input  wire logic                           suspend,
  input  wire logic                           clear_tempo,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [tta_pkg::TEMPO_W-1:0]         tempo_ms,
  output logic [tta_pkg::EV_W-1:0]            tap_event
);
  import tta_pkg::*;

  localparam int SUM_W = HIST_W + $clog2(HISTORY_DEPTH);
  localparam int DIV_W = $clog2(HISTORY_DEPTH * TICKS_PER_MS + 1);

  logic                  push;
  cmd_t                  push_cmd;
  logic                  pop;
  cmd_t                  head_cmd;
  logic [FIFO_LVL_W-1:0] level;
  logic                  queue_full;
  logic                  div_start;
  logic [SUM_W-1:0]      div_dividend;
  logic [DIV_W-1:0]      div_divisor;
  logic                  div_busy;
  logic [SUM_W-1:0]      div_quotient;

  assign queue_full = (level == FIFO_LVL_W'(FIFO_DEPTH));

  // Tick classification.
  tta_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .switch_pressed (switch_pressed),
    .suspend        (suspend),
    .clear_tempo    (clear_tempo),
    .queue_full     (queue_full),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  // Command queue.
  tta_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .pop       (pop),
    .pop_data  (head_cmd),
    .level     (level)
  );

  // Ring, tempo and output register.
  tta_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .TICKS_PER_MS  (TICKS_PER_MS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (level != '0),
    .cmd          (head_cmd),
    .cmd_pop      (pop),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_busy     (div_busy),
    .div_quotient (div_quotient),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .tempo_ms     (tempo_ms),
    .tap_event    (tap_event)
  );

  // Serial divider for the average.
  tta_div #(
    .SUM_W (SUM_W),
    .DIV_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quotient (div_quotient)
  );

  // A division is never started on top of one still running.
  a_div_start_idle : assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // A started division is running in the following cycle.
  a_div_runs : assert property (@(posedge clk) disable iff (rst)
    div_start |=> div_busy)
    else $error("divider did not start");

  // A transferred tick is waiting in the queue in the next cycle.
  a_tick_queued : assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (level != '0))
    else $error("accepted tick missing from queue");

  // A recorded interval always has a nonzero divisor.
  a_divisor_nonzero : assert property (@(posedge clk) disable iff (rst)
    div_start |-> (div_divisor != '0))
    else $error("division by zero requested");

endmodule

`default_nettype wire

@@ src/tta_fifo.sv @@
// ----------------------------------------------------------------------------
// Tap tempo averager command queue
// A short register queue of classified ticks between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tta_fifo (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire tta_pkg::cmd_t               push_data,
  input  wire logic                        pop,
  output tta_pkg::cmd_t                    pop_data,
  output logic [tta_pkg::FIFO_LVL_W-1:0]   level
);
  import tta_pkg::*;

  cmd_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;

  // Head of the queue is shown directly.
  assign pop_data = mem[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        level <= level + 1'b1;
      end else if (pop && !push) begin
        level <= level - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ src/tta_front.sv @@
// ----------------------------------------------------------------------------
// Tap tempo averager front end
// Holds the configuration, runs the interval and press counters once per
// tick and classifies each accepted tap into a command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module tta_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [tta_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tta_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         switch_pressed,
  input  wire logic                         suspend,
  input  wire logic                         clear_tempo,
  input  wire logic                         queue_full,
  output logic                              push,
  output tta_pkg::cmd_t                     push_cmd
);
  import tta_pkg::*;

  logic [PRESS_W-1:0]    debounce_ticks;
  logic [HIST_W-1:0]     min_interval_ticks;
  logic [HIST_W-1:0]     max_interval_ticks;
  logic [INTERVAL_W-1:0] interval_count;
  logic [INTERVAL_W-1:0] interval_count_next;
  logic [PRESS_W-1:0]    press_count;
  logic [PRESS_W-1:0]    press_count_next;
  logic [INTERVAL_W-1:0] interval_inc;
  logic [PRESS_W-1:0]    press_inc;
  logic [EV_W-1:0]       ev;

  // A tick is taken whenever the queue has room and reset is low.
  assign in_ready = !rst && !queue_full;
  assign push     = in_valid && in_ready;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks     <= DEBOUNCE_RST;
      min_interval_ticks <= MIN_INT_RST;
      max_interval_ticks <= MAX_INT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DEBOUNCE: debounce_ticks     <= cfg_data[PRESS_W-1:0];
        CFG_MIN_INT:  min_interval_ticks <= cfg_data[HIST_W-1:0];
        CFG_MAX_INT:  max_interval_ticks <= cfg_data[HIST_W-1:0];
        default: ;
      endcase
    end
  end

  // Counter update and tap classification for one tick.
  always_comb begin
    interval_inc = (interval_count != INTERVAL_MAX) ? interval_count + 1'b1
                                                    : interval_count;
    press_inc           = press_count + 1'b1;
    interval_count_next = interval_inc;
    press_count_next    = press_count;
    ev                  = EV_NONE;
    if (!suspend) begin
      if (switch_pressed) begin
        if (press_count != PRESS_MAX) begin
          press_count_next = press_inc;
          if (press_inc == debounce_ticks) begin
            // The order of the checks settles overlapping limits.
            if (interval_inc < {1'b0, min_interval_ticks}) begin
              ev = EV_SOON;
            end else if (interval_inc < {1'b0, max_interval_ticks}) begin
              ev = EV_REC;
            end else begin
              ev = EV_RESTART;
            end
            interval_count_next = '0;
          end
        end
      end else begin
        press_count_next = '0;
      end
    end
    push_cmd.clear    = clear_tempo;
    push_cmd.ev       = ev;
    push_cmd.interval = interval_inc[HIST_W-1:0];
  end

  // Counters advance on each transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      interval_count <= INTERVAL_MAX;
      press_count    <= '0;
    end else if (push) begin
      interval_count <= interval_count_next;
      press_count    <= press_count_next;
    end
  end

endmodule

`default_nettype wire

@@ src/tta_div.sv @@
// ----------------------------------------------------------------------------
// Tap tempo averager divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tta_div #(
  parameter int SUM_W = 14,
  parameter int DIV_W = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] dividend,
  input  wire logic [DIV_W-1:0] divisor,
  output logic                  busy,
  output logic [SUM_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(SUM_W);

  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dvs;
  logic [DIV_W:0]   trial;
  logic [DIV_W:0]   diff;
  logic             ge;

  // One trial subtraction per cycle.
  always_comb begin
    trial = {rem, quotient[SUM_W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = trial >= {1'b0, dvs};
  end

  // Iteration control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(SUM_W - 1);
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  // Remainder and quotient shift.
  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= '0;
      dvs      <= divisor;
      quotient <= dividend;
    end else if (busy) begin
      rem      <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quotient <= {quotient[SUM_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

@@ src/tta_back.sv @@
// ----------------------------------------------------------------------------
// Tap tempo averager back end
// Carries out queued commands: keeps the interval ring, its running sum and
// the tempo, starts the divider for a recorded interval and drives the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tta_back #(
  parameter int HISTORY_DEPTH = 4,
  parameter int TICKS_PER_MS  = 4,
  localparam int SUM_W = tta_pkg::HIST_W + $clog2(HISTORY_DEPTH),
  localparam int DIV_W = $clog2(HISTORY_DEPTH * TICKS_PER_MS + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cmd_valid,
  input  wire tta_pkg::cmd_t            cmd,
  output logic                          cmd_pop,
  output logic                          div_start,
  output logic [SUM_W-1:0]              div_dividend,
  output logic [DIV_W-1:0]              div_divisor,
  input  wire logic                     div_busy,
  input  wire logic [SUM_W-1:0]         div_quotient,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [tta_pkg::TEMPO_W-1:0]   tempo_ms,
  output logic [tta_pkg::EV_W-1:0]      tap_event
);
  import tta_pkg::*;

  localparam int SLOT_W = $clog2(HISTORY_DEPTH);
  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  logic              state;
  logic [HIST_W-1:0] history [HISTORY_DEPTH];
  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] write_slot_next;
  logic [FILL_W-1:0] fill_count;
  logic [FILL_W-1:0] fill_count_next;
  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sum_next;
  logic [TEMPO_W-1:0] tempo_value;
  logic [TEMPO_W-1:0] tempo_cleared;
  logic [TEMPO_W-1:0] tempo_avg;
  logic              out_free;
  logic              is_rec;
  logic              is_restart;
  logic              div_take;
  logic              load_direct;

  // Command decode and ring bookkeeping.
  always_comb begin
    out_free      = !out_valid || out_ready;
    is_rec        = (cmd.ev == EV_REC);
    is_restart    = (cmd.ev == EV_RESTART);
    tempo_cleared = cmd.clear ? '0 : tempo_value;
    cmd_pop       = (state == ST_IDLE) && cmd_valid && out_free;
    load_direct   = cmd_pop && !is_rec;
    div_take      = (state == ST_DIV) && !div_busy && out_free;

    write_slot_next = (write_slot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0
                                                                 : write_slot + 1'b1;
    fill_count_next = (fill_count != FILL_W'(HISTORY_DEPTH)) ? fill_count + 1'b1
                                                             : fill_count;
    // The running sum swaps the overwritten slot for the new interval.
    sum_next = sum - SUM_W'(history[write_slot]) + SUM_W'(cmd.interval);

    div_start    = cmd_pop && is_rec;
    div_dividend = sum_next;
    div_divisor  = DIV_W'(fill_count_next) * DIV_W'(TICKS_PER_MS);

    // Averages above the output range saturate.
    tempo_avg = (div_quotient > SUM_W'(TEMPO_MAX)) ? TEMPO_MAX
                                                  : div_quotient[TEMPO_W-1:0];
  end

  // Sequencer, ring and tempo state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      out_valid   <= 1'b0;
      write_slot  <= '0;
      fill_count  <= '0;
      sum         <= '0;
      tempo_value <= '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        history[i] <= '0;
      end
    end else begin
      // A result stays offered until its transfer, and a new one is loaded
      // only when the register is free.
      out_valid <= load_direct || div_take || (out_valid && !out_ready);
      if (cmd_pop) begin
        tempo_value <= tempo_cleared;
        if (is_rec) begin
          history[write_slot] <= cmd.interval;
          write_slot          <= write_slot_next;
          fill_count          <= fill_count_next;
          sum                 <= sum_next;
          state               <= ST_DIV;
        end else begin
          if (is_restart) begin
            write_slot <= '0;
            fill_count <= '0;
            sum        <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
              history[i] <= '0;
            end
          end
        end
      end
      if (div_take) begin
        tempo_value <= tempo_avg;
        state       <= ST_IDLE;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load_direct) begin
      tempo_ms  <= tempo_cleared;
      tap_event <= cmd.ev;
    end else if (div_take) begin
      tempo_ms  <= tempo_avg;
      tap_event <= EV_REC;
    end
  end

endmodule

`default_nettype wire
